// ===== rtl/core/twrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package twrm_pkg;

   localparam int THREADS = 16;
   localparam int THREAD_W = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int SUM_W = 24 + ((THREADS > 1) ? $clog2(THREADS) : 0);

   localparam logic [23:0] RATE_MAX = 24'hFFFFFF;
   localparam logic [35:0] SUM_MAX = 36'hFFFFFFF;
   localparam logic [23:0] RESET_RATE = 24'd65536;
   localparam logic [48:0] K_E_Q16 = 49'd178258;
   localparam logic [23:0] LN2_Q16 = 24'd45426;
   localparam logic [23:0] NEW_W_Q16 = 24'd42598;
   localparam logic [23:0] OLD_W_Q16 = 24'd22938;

   localparam logic REG_INITIAL_RATE = 1'b0;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
   localparam logic [OP_W-1:0] OP_READ    = 5'd2;
   localparam logic [OP_W-1:0] OP_WAKE    = 5'd3;
   localparam logic [OP_W-1:0] OP_DIV     = 5'd4;
   localparam logic [OP_W-1:0] OP_LOAD_A1 = 5'd5;
   localparam logic [OP_W-1:0] OP_NORM    = 5'd6;
   localparam logic [OP_W-1:0] OP_LOG1    = 5'd7;
   localparam logic [OP_W-1:0] OP_LOG2    = 5'd8;
   localparam logic [OP_W-1:0] OP_MUL1    = 5'd9;
   localparam logic [OP_W-1:0] OP_MUL2    = 5'd10;
   localparam logic [OP_W-1:0] OP_MUL3    = 5'd11;
   localparam logic [OP_W-1:0] OP_MUL4    = 5'd12;
   localparam logic [OP_W-1:0] OP_MUL5    = 5'd13;
   localparam logic [OP_W-1:0] OP_SLEEP   = 5'd14;
   localparam logic [OP_W-1:0] OP_OUT     = 5'd15;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } ctl_type;

   typedef struct packed {
      logic valid;
      logic cmd;
      logic want;
      logic cur;
      logic div_last;
      logic norm_done;
   } sts_type;

   function automatic logic [15:0] lg_frac(input logic [5:0] k);
      logic [15:0] v;
      case (k)
         6'd0: v = 16'd0;      6'd1: v = 16'd1466;   6'd2: v = 16'd2909;
         6'd3: v = 16'd4331;   6'd4: v = 16'd5732;   6'd5: v = 16'd7112;
         6'd6: v = 16'd8473;   6'd7: v = 16'd9814;   6'd8: v = 16'd11136;
         6'd9: v = 16'd12440;  6'd10: v = 16'd13727; 6'd11: v = 16'd14996;
         6'd12: v = 16'd16248; 6'd13: v = 16'd17484; 6'd14: v = 16'd18704;
         6'd15: v = 16'd19909; 6'd16: v = 16'd21098; 6'd17: v = 16'd22272;
         6'd18: v = 16'd23433; 6'd19: v = 16'd24579; 6'd20: v = 16'd25711;
         6'd21: v = 16'd26830; 6'd22: v = 16'd27936; 6'd23: v = 16'd29029;
         6'd24: v = 16'd30109; 6'd25: v = 16'd31178; 6'd26: v = 16'd32234;
         6'd27: v = 16'd33279; 6'd28: v = 16'd34312; 6'd29: v = 16'd35334;
         6'd30: v = 16'd36346; 6'd31: v = 16'd37346; 6'd32: v = 16'd38336;
         6'd33: v = 16'd39316; 6'd34: v = 16'd40286; 6'd35: v = 16'd41246;
         6'd36: v = 16'd42196; 6'd37: v = 16'd43137; 6'd38: v = 16'd44068;
         6'd39: v = 16'd44990; 6'd40: v = 16'd45904; 6'd41: v = 16'd46809;
         6'd42: v = 16'd47705; 6'd43: v = 16'd48593; 6'd44: v = 16'd49472;
         6'd45: v = 16'd50344; 6'd46: v = 16'd51207; 6'd47: v = 16'd52063;
         6'd48: v = 16'd52911; 6'd49: v = 16'd53751; 6'd50: v = 16'd54584;
         6'd51: v = 16'd55410; 6'd52: v = 16'd56229; 6'd53: v = 16'd57040;
         6'd54: v = 16'd57845; 6'd55: v = 16'd58643; 6'd56: v = 16'd59434;
         6'd57: v = 16'd60219; 6'd58: v = 16'd60997; 6'd59: v = 16'd61769;
         6'd60: v = 16'd62534; 6'd61: v = 16'd63294; 6'd62: v = 16'd64047;
         default: v = 16'd64794;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/twrm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module twrm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  twrm_pkg::sts_type sts,
   output twrm_pkg::ctl_type ctl
);
   import twrm_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_READ   = 5'd1;
   localparam logic [4:0] S_DECIDE = 5'd2;
   localparam logic [4:0] S_DIV    = 5'd3;
   localparam logic [4:0] S_LOAD1  = 5'd4;
   localparam logic [4:0] S_NORM1  = 5'd5;
   localparam logic [4:0] S_LOG1   = 5'd6;
   localparam logic [4:0] S_NORM2  = 5'd7;
   localparam logic [4:0] S_LOG2   = 5'd8;
   localparam logic [4:0] S_M1     = 5'd9;
   localparam logic [4:0] S_M2     = 5'd10;
   localparam logic [4:0] S_M3     = 5'd11;
   localparam logic [4:0] S_M4     = 5'd12;
   localparam logic [4:0] S_M5     = 5'd13;
   localparam logic [4:0] S_COMMIT = 5'd14;
   localparam logic [4:0] S_OUT    = 5'd15;

   logic [4:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl.op = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.op = OP_LOAD;
               state_in = S_READ;
            end
         end
         S_READ: begin
            ctl.op = OP_READ;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!sts.valid || sts.cmd || (sts.cur == sts.want)) begin
               state_in = S_OUT;
            end else if (sts.want) begin
               ctl.op = OP_WAKE;
               state_in = S_OUT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            ctl.op = OP_DIV;
            if (sts.div_last) state_in = S_LOAD1;
         end
         S_LOAD1: begin
            ctl.op = OP_LOAD_A1;
            state_in = S_NORM1;
         end
         S_NORM1: begin
            ctl.op = OP_NORM;
            if (sts.norm_done) state_in = S_LOG1;
         end
         S_LOG1: begin
            ctl.op = OP_LOG1;
            state_in = S_NORM2;
         end
         S_NORM2: begin
            ctl.op = OP_NORM;
            if (sts.norm_done) state_in = S_LOG2;
         end
         S_LOG2: begin
            ctl.op = OP_LOG2;
            state_in = S_M1;
         end
         S_M1: begin
            ctl.op = OP_MUL1;
            state_in = S_M2;
         end
         S_M2: begin
            ctl.op = OP_MUL2;
            state_in = S_M3;
         end
         S_M3: begin
            ctl.op = OP_MUL3;
            state_in = S_M4;
         end
         S_M4: begin
            ctl.op = OP_MUL4;
            state_in = S_M5;
         end
         S_M5: begin
            ctl.op = OP_MUL5;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            ctl.op = OP_SLEEP;
            state_in = S_OUT;
         end
         S_OUT: begin
            ctl.op = OP_OUT;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/twrm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module twrm_dpath (
   input  logic              clock,
   input  logic              reset,
   input  twrm_pkg::ctl_type ctl,
   output twrm_pkg::sts_type sts,
   input  logic              cfg_we,
   input  logic [23:0]       cfg_data,
   output logic [23:0]       init_rate,
   input  logic              req_command,
   input  logic [3:0]        req_thread_id,
   input  logic              req_new_state,
   input  logic [31:0]       req_now_us,
   output logic              rsp_valid,
   output logic [3:0]        rsp_thread_out,
   output logic              rsp_state_out,
   output logic [23:0]       rsp_rate_out,
   output logic [27:0]       rsp_rate_sum,
   output logic [31:0]       rsp_last_idle_span
);
   import twrm_pkg::*;

   logic              st_ff   [THREADS];
   logic [31:0]       ct_ff   [THREADS];
   logic [31:0]       isp_ff  [THREADS];
   logic [23:0]       rate_ff [THREADS];
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [23:0]       init_ff;

   logic              cmd_ff, want_ff, valid_ff;
   logic [3:0]        id_ff;
   logic [31:0]       now_ff;
   logic [THREAD_W-1:0] idx;

   logic [31:0]       w_ff, w_in;
   logic [32:0]       s_ff, s_in;
   logic [23:0]       old_ff;
   logic [33:0]       rem_ff, rem_in, trial, diff;
   logic [16:0]       q_ff, q_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              ge;
   logic [48:0]       x_ff, x_in, a1, a2;
   logic [5:0]        sh_ff, sh_in;
   logic [21:0]       lg_cur, lg1_ff, lg1_in, lg2_ff, lg2_in;
   logic [23:0]       ln1_ff, ln1_in;
   logic [47:0]       prod_ff, prod_in, acc_ff, acc_in;
   logic [23:0]       mul_a, mul_b, rnd24;
   logic [47:0]       rnd_full, nr_full;
   logic [23:0]       nr_sat;
   logic [35:0]       sum_x;

   assign idx = THREAD_W'(id_ff);
   assign init_rate = init_ff;

   assign sts.valid     = valid_ff;
   assign sts.cmd       = cmd_ff;
   assign sts.want      = want_ff;
   assign sts.cur       = st_ff[idx];
   assign sts.div_last  = (cnt_ff == 5'd16);
   assign sts.norm_done = x_ff[48];

   assign trial = (cnt_ff == 5'd0) ? rem_ff : {rem_ff[32:0], 1'b0};
   assign ge    = (s_ff != 33'd0) && (trial >= {1'b0, s_ff});
   assign diff  = trial - {1'b0, s_ff};
   assign a1    = K_E_Q16 + 49'(q_ff);
   assign a2    = {s_ff, 16'd0} + K_E_Q16;
   assign lg_cur = {6'(6'd32 - sh_ff), 16'd0} + 22'(lg_frac(x_ff[47:42]));
   assign rnd_full = (prod_ff + 48'd32768) >> 16;
   assign rnd24 = rnd_full[23:0];
   assign nr_full = (acc_ff + prod_ff + 48'd32768) >> 16;
   assign nr_sat = (nr_full > 48'(RATE_MAX)) ? RATE_MAX : nr_full[23:0];
   assign sum_x = 36'(sum_ff);

   always_comb begin
      w_in = w_ff;
      s_in = s_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      x_in = x_ff;
      sh_in = sh_ff;
      lg1_in = lg1_ff;
      lg2_in = lg2_ff;
      ln1_in = ln1_ff;
      acc_in = acc_ff;
      mul_a = 24'd0;
      mul_b = 24'd0;
      sum_in = sum_ff;
      case (ctl.op)
         OP_READ: begin
            w_in = now_ff - ct_ff[idx];
            s_in = {1'b0, w_in} + {1'b0, isp_ff[idx]};
            rem_in = {2'b00, w_in};
            q_in = 17'd0;
            cnt_in = 5'd0;
         end
         OP_DIV: begin
            q_in = {q_ff[15:0], ge};
            rem_in = ge ? diff : trial;
            cnt_in = cnt_ff + 5'd1;
         end
         OP_LOAD_A1: begin
            x_in = a1;
            sh_in = 6'd0;
         end
         OP_NORM: begin
            if (x_ff[48:41] == 8'd0) begin
               x_in = {x_ff[40:0], 8'd0};
               sh_in = sh_ff + 6'd8;
            end else if (!x_ff[48]) begin
               x_in = {x_ff[47:0], 1'b0};
               sh_in = sh_ff + 6'd1;
            end
         end
         OP_LOG1: begin
            lg1_in = lg_cur;
            x_in = a2;
            sh_in = 6'd0;
         end
         OP_LOG2: lg2_in = lg_cur;
         OP_MUL1: begin
            mul_a = 24'(lg1_ff);
            mul_b = LN2_Q16;
         end
         OP_MUL2: begin
            ln1_in = rnd24;
            mul_a = 24'(lg2_ff);
            mul_b = LN2_Q16;
         end
         OP_MUL3: begin
            mul_a = ln1_ff;
            mul_b = rnd24;
         end
         OP_MUL4: begin
            mul_a = rnd24;
            mul_b = NEW_W_Q16;
         end
         OP_MUL5: begin
            acc_in = prod_ff;
            mul_a = old_ff;
            mul_b = OLD_W_Q16;
         end
         OP_SLEEP: sum_in = sum_ff - SUM_W'(old_ff) + SUM_W'(nr_sat);
         default: ;
      endcase
      if (cfg_we) sum_in = SUM_W'(36'(cfg_data) * 36'(THREADS));
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      s_ff <= s_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      x_ff <= x_in;
      sh_ff <= sh_in;
      lg1_ff <= lg1_in;
      lg2_ff <= lg2_in;
      ln1_ff <= ln1_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      if (ctl.op == OP_READ) old_ff <= rate_ff[idx];
      if (ctl.op == OP_LOAD) begin
         cmd_ff <= req_command;
         id_ff <= req_thread_id;
         want_ff <= req_new_state;
         now_ff <= req_now_us;
         valid_ff <= (32'(req_thread_id) < THREADS);
      end
      if (ctl.op == OP_OUT) begin
         rsp_thread_out <= id_ff;
         rsp_state_out <= valid_ff ? st_ff[idx] : 1'b0;
         rsp_rate_out <= valid_ff ? rate_ff[idx] : 24'd0;
         rsp_last_idle_span <= valid_ff ? isp_ff[idx] : 32'd0;
         rsp_rate_sum <= (sum_x > SUM_MAX) ? SUM_MAX[27:0] : sum_x[27:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
         init_ff <= RESET_RATE;
         sum_ff <= SUM_W'(36'(RESET_RATE) * 36'(THREADS));
         for (int t = 0; t < THREADS; t++) begin
            st_ff[t] <= 1'b0;
            ct_ff[t] <= 32'd0;
            isp_ff[t] <= 32'd0;
            rate_ff[t] <= RESET_RATE;
         end
      end else begin
         rsp_valid <= (ctl.op == OP_OUT);
         sum_ff <= sum_in;
         if (cfg_we) begin
            init_ff <= cfg_data;
            for (int t = 0; t < THREADS; t++) rate_ff[t] <= cfg_data;
         end
         if (ctl.op == OP_WAKE) begin
            isp_ff[idx] <= w_ff;
            ct_ff[idx] <= now_ff;
            st_ff[idx] <= 1'b1;
         end
         if (ctl.op == OP_SLEEP) begin
            rate_ff[idx] <= nr_sat;
            ct_ff[idx] <= now_ff;
            st_ff[idx] <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/thread_work_rate_monitor_core.sv =====
// channel   | handshake               | payload
// request   | start, busy             | req_command, req_thread_id, req_new_state, req_now_us
// response  | rsp_valid (one cycle)   | rsp_thread_out, rsp_state_out, rsp_rate_out,
//           |                         | rsp_rate_sum, rsp_last_idle_span
// config    | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// a query or a no-change item and an idle to working change pass through the read,
// decide and out states to rsp_valid; a working to idle change takes longer, set by the
// 17-step divider, the two leading-one normalizations and the shared multiplier
// busy stays high until the result strobe; reset is synchronous and loads the rates
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
module thread_work_rate_monitor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [3:0]  req_thread_id,
   input  logic        req_new_state,
   input  logic [31:0] req_now_us,
   output logic        rsp_valid,
   output logic [3:0]  rsp_thread_out,
   output logic        rsp_state_out,
   output logic [23:0] rsp_rate_out,
   output logic [27:0] rsp_rate_sum,
   output logic [31:0] rsp_last_idle_span,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import twrm_pkg::*;

   ctl_type     ctl;
   sts_type     sts;
   logic        cfg_we;
   logic [23:0] init_rate;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_INITIAL_RATE);
   assign prdata = (paddr[2] == REG_INITIAL_RATE) ? {8'd0, init_rate} : 32'd0;

   twrm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   twrm_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .cfg_we             (cfg_we),
      .cfg_data           (pwdata[23:0]),
      .init_rate          (init_rate),
      .req_command        (req_command),
      .req_thread_id      (req_thread_id),
      .req_new_state      (req_new_state),
      .req_now_us         (req_now_us),
      .rsp_valid          (rsp_valid),
      .rsp_thread_out     (rsp_thread_out),
      .rsp_state_out      (rsp_state_out),
      .rsp_rate_out       (rsp_rate_out),
      .rsp_rate_sum       (rsp_rate_sum),
      .rsp_last_idle_span (rsp_last_idle_span)
   );

endmodule
`default_nettype wire

// ===== dv/tb_thread_work_rate_monitor_core.sv =====
`timescale 1ns / 1ps
module tb_thread_work_rate_monitor_core;
   import twrm_pkg::*;

   localparam logic [2:0] ADDR_INITIAL_RATE = 3'd0;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic CMD_SET = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   typedef struct packed {
      logic [3:0]  thread_out;
      logic        state_out;
      logic [23:0] rate_out;
      logic [27:0] rate_sum;
      logic [31:0] idle_span;
   } status_t;

   typedef struct {
      logic        cmd;
      logic [3:0]  tid;
      logic        want;
      logic [31:0] now;
      logic        known;
      status_t     fixed;
   } row_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_command = 0;
   logic [3:0] req_thread_id = 0;
   logic req_new_state = 0;
   logic [31:0] req_now_us = 0;
   logic rsp_valid;
   logic [3:0] rsp_thread_out;
   logic rsp_state_out;
   logic [23:0] rsp_rate_out;
   logic [27:0] rsp_rate_sum;
   logic [31:0] rsp_last_idle_span;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   thread_work_rate_monitor_core dut (.*);

   always #4 clock = ~clock;

   logic        th_state [16];
   logic [31:0] th_change [16];
   logic [31:0] th_idle [16];
   logic [23:0] th_rate [16];
   logic [27:0] total_rate;
   status_t     pending_status [$];
   int          errors = 0;
   int          cycles = 0;
   int          gap_pct = 0;
   logic [31:0] clock_us = 0;

   function automatic logic [63:0] log2_fix(input logic [63:0] x);
      int n;
      logic [15:0] frac_tab [64] = '{
         0, 1466, 2909, 4331, 5732, 7112, 8473, 9814, 11136, 12440, 13727, 14996,
         16248, 17484, 18704, 19909, 21098, 22272, 23433, 24579, 25711, 26830,
         27936, 29029, 30109, 31178, 32234, 33279, 34312, 35334, 36346, 37346,
         38336, 39316, 40286, 41246, 42196, 43137, 44068, 44990, 45904, 46809,
         47705, 48593, 49472, 50344, 51207, 52063, 52911, 53751, 54584, 55410,
         56229, 57040, 57845, 58643, 59434, 60219, 60997, 61769, 62534, 63294,
         64047, 64794};
      if (x < 64'd65536) return 0;
      n = 63;
      while (!x[n]) n--;
      return (64'(n - 16) << 16) + frac_tab[(x >> (n - 6)) & 63];
   endfunction

   function automatic logic [63:0] ln_fix(input logic [63:0] x);
      return (log2_fix(x) * 64'd45426 + 64'd32768) >> 16;
   endfunction

   function automatic void resum_rates();
      logic [63:0] s;
      s = 0;
      for (int t = 0; t < 16; t++) s += th_rate[t];
      total_rate = (s > 64'hFFFFFFF) ? 28'hFFFFFFF : s[27:0];
   endfunction

   function automatic void load_rates(input logic [23:0] v);
      for (int t = 0; t < 16; t++) th_rate[t] = v;
      resum_rates();
   endfunction

   function automatic status_t predict_status(input logic cmd, input logic [3:0] tid,
                                              input logic want, input logic [31:0] now);
      logic [31:0] span;
      logic [63:0] w, s, r, l1, l2, p, nr;
      status_t o;
      if (cmd == CMD_SET) begin
         span = now - th_change[tid];
         if (th_state[tid] == ST_IDLE && want == ST_WORK) begin
            th_idle[tid] = span;
            th_change[tid] = now;
            th_state[tid] = ST_WORK;
         end else if (th_state[tid] == ST_WORK && want == ST_IDLE) begin
            w = span;
            s = w + th_idle[tid];
            r = (s != 0) ? (w << 16) / s : 0;
            l1 = ln_fix(64'd178258 + r);
            l2 = ln_fix((s << 16) + 64'd178258);
            p = (l1 * l2 + 64'd32768) >> 16;
            nr = (p * 64'd42598 + 64'(th_rate[tid]) * 64'd22938 + 64'd32768) >> 16;
            th_rate[tid] = (nr > 64'hFFFFFF) ? 24'hFFFFFF : nr[23:0];
            th_change[tid] = now;
            th_state[tid] = ST_IDLE;
            resum_rates();
         end
      end
      o.thread_out = tid;
      o.state_out = th_state[tid];
      o.rate_out = th_rate[tid];
      o.rate_sum = total_rate;
      o.idle_span = th_idle[tid];
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_thread_work_rate_monitor_core failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      status_t got, want_s;
      if (!reset && rsp_valid) begin
         got = {rsp_thread_out, rsp_state_out, rsp_rate_out, rsp_rate_sum,
                rsp_last_idle_span};
         if (pending_status.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
         end else begin
            want_s = pending_status.pop_front();
            if (got !== want_s) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch exp thr %0d st %0d rate %0d sum %0d idle %0d",
                            " / got thr %0d st %0d rate %0d sum %0d idle %0d"},
                           want_s.thread_out, want_s.state_out, want_s.rate_out,
                           want_s.rate_sum, want_s.idle_span, got.thread_out,
                           got.state_out, got.rate_out, got.rate_sum, got.idle_span);
            end
         end
      end
   end

   task automatic write_rate(input logic [23:0] v);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_INITIAL_RATE;
      pwdata <= {8'h0, v};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      load_rates(v);
   endtask

   task automatic wait_drained();
      while (pending_status.size() != 0 || busy) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic issue(input logic cmd, input logic [3:0] tid, input logic want,
                        input logic [31:0] now, input logic known, input status_t fixed);
      status_t p;
      while ($urandom_range(99) < gap_pct) @(posedge clock);
      req_command <= cmd; req_thread_id <= tid; req_new_state <= want; req_now_us <= now;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = predict_status(cmd, tid, want, now);
      if (known && p !== fixed) begin
         errors++;
         if (errors <= 10) $display("table row disagrees with prediction %h", p);
      end
      pending_status = {pending_status, p};
      start <= 0;
      @(posedge clock);
   endtask

   task automatic random_items(input int n);
      logic [3:0] tid;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         tid = 4'($urandom_range(15));
         if (k < 10)
            clock_us = $urandom;
         else if (k < 85)
            clock_us = clock_us + (($urandom_range(3) == 0) ? $urandom : $urandom_range(5000));
         if (k >= 90)
            issue(CMD_QUERY, tid, 1'($urandom_range(1)), clock_us, 0, '0);
         else
            issue(CMD_SET, tid, (k < 80) ? ~th_state[tid] : 1'($urandom_range(1)),
                  clock_us, 0, '0);
      end
   endtask

   row_t dir_rows [$];

   initial begin
      row_t rw;
      load_rates(RESET_RATE);
      for (int t = 0; t < 16; t++) begin
         th_state[t] = ST_IDLE; th_change[t] = 0; th_idle[t] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir_rows = '{
         '{CMD_QUERY, 4'd0, ST_WORK, 32'd0, 1, '{4'd0, ST_IDLE, 24'd65536, 28'd1048576, 32'd0}},
         '{CMD_QUERY, 4'd15, ST_IDLE, 32'hFFFFFFFF, 1,
           '{4'd15, ST_IDLE, 24'd65536, 28'd1048576, 32'd0}},
         '{CMD_SET, 4'd3, ST_IDLE, 32'd100, 1, '{4'd3, ST_IDLE, 24'd65536, 28'd1048576, 32'd0}},
         '{CMD_SET, 4'd3, ST_WORK, 32'd100, 1, '{4'd3, ST_WORK, 24'd65536, 28'd1048576, 32'd100}},
         '{CMD_SET, 4'd3, ST_WORK, 32'd500, 0, '0},
         '{CMD_SET, 4'd3, ST_IDLE, 32'd100, 0, '0},
         '{CMD_SET, 4'd5, ST_WORK, 32'hFFFFFFF0, 0, '0},
         '{CMD_SET, 4'd5, ST_IDLE, 32'h00000010, 0, '0},
         '{CMD_SET, 4'd7, ST_WORK, 32'hFFFFFFFF, 0, '0},
         '{CMD_SET, 4'd7, ST_IDLE, 32'h7FFFFFFF, 0, '0},
         '{CMD_SET, 4'd15, ST_WORK, 32'h0, 0, '0},
         '{CMD_SET, 4'd15, ST_IDLE, 32'hFFFFFFFF, 0, '0},
         '{CMD_QUERY, 4'd7, ST_IDLE, 32'h5555AAAA, 0, '0},
         '{CMD_SET, 4'd0, ST_WORK, 32'hAAAA5555, 0, '0},
         '{CMD_SET, 4'd0, ST_IDLE, 32'hAAAA5555, 0, '0}
      };
      foreach (dir_rows[i]) begin
         rw = dir_rows[i];
         issue(rw.cmd, rw.tid, rw.want, rw.now, rw.known, rw.fixed);
      end
      wait_drained();

      write_rate(24'hFFFFFF);
      issue(CMD_QUERY, 4'd9, ST_IDLE, 32'd0, 1,
            '{4'd9, th_state[9], 24'hFFFFFF, 28'hFFFFFF0, th_idle[9]});
      gap_pct = 21;
      random_items(200);
      wait_drained();
      write_rate(24'd0);
      gap_pct = 62;
      random_items(150);
      wait_drained();
      write_rate(24'($urandom_range(24'hFFFFFF)));
      gap_pct = 0;
      random_items(200);
      wait_drained();
      write_rate(RESET_RATE);
      random_items(150);

      wait_drained();
      if (errors == 0)
         $display("tb_thread_work_rate_monitor_core passed");
      else
         $display("tb_thread_work_rate_monitor_core failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/twrm_pkg.sv
rtl/core/twrm_ctrl.sv
rtl/core/twrm_dpath.sv
rtl/core/thread_work_rate_monitor_core.sv
dv/tb_thread_work_rate_monitor_core.sv
